[sv/sample_format_converter_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sample format converter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_FORMAT_CONVERTER_CORE_ASSERT_SVH
`define SAMPLE_FORMAT_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication
`define SFC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared format codes, path codes and pipeline constants.
// ----------------------------------------------------------------------------
package sfc_pkg;

    typedef logic [1:0] fmt_t;
    typedef logic [1:0] path_t;

    // Sample format codes
    localparam fmt_t FMT_I16        = 2'd0;
    localparam fmt_t FMT_I16_ON_I32 = 2'd1;
    localparam fmt_t FMT_I32        = 2'd2;
    localparam fmt_t FMT_F32        = 2'd3;

    // Register indexes
    localparam logic CFG_INPUT_FORMAT  = 1'b0;
    localparam logic CFG_OUTPUT_FORMAT = 1'b1;

    // Which unit produces the result of an item
    localparam path_t PATH_SIMPLE = 2'd0;
    localparam path_t PATH_I2F    = 2'd1;
    localparam path_t PATH_F2I    = 2'd2;

    // Pipeline depths
    localparam int STAGES     = 6;
    localparam int F2I_STAGES = 4;

endpackage

[sv/sfc_int2flt.sv]
// ----------------------------------------------------------------------------
// sfc_int2flt
// Integer to single float, divided by 32767 or by 2^31, six register stages.
// ----------------------------------------------------------------------------
module sfc_int2flt
(
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       sample,
    input  sfc_pkg::fmt_t     in_fmt,
    output logic [31:0]       result
);
    import sfc_pkg::*;

    // stage 1: sign and magnitude
    logic        s1_sign_reg, s1_sign_next;
    logic [31:0] s1_mag_reg, s1_mag_next;
    logic        s1_div_reg, s1_div_next;
    logic [31:0] src;

    always_comb
    begin
        src = (in_fmt == FMT_I16) ? {{16{sample[15]}}, sample[15:0]} : sample;
        s1_sign_next = src[31];
        s1_mag_next  = src[31] ? (~src + 32'd1) : src;
        s1_div_next  = (in_fmt != FMT_I32);
    end

    // stage 2: leading one search and normalise
    logic        s2_sign_reg, s2_div_reg, s2_zero_reg;
    logic [31:0] s2_norm_reg, s2_norm_next;
    logic [4:0]  s2_pos_reg, s2_pos_next;
    logic        s2_zero_next;

    always_comb
    begin
        s2_pos_next = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (s1_mag_reg[i])
                s2_pos_next = 5'(i);
        end
        s2_zero_next = (s1_mag_reg == 32'd0);
        s2_norm_next = s1_mag_reg << (5'd31 - s2_pos_next);
    end

    // stage 3: round to 24 bits, nearest even
    logic        s3_sign_reg, s3_div_reg, s3_zero_reg;
    logic [23:0] s3_mant_reg, s3_mant_next;
    logic [5:0]  s3_exp_reg, s3_exp_next;
    logic        rnd3;
    logic [24:0] sum3;

    always_comb
    begin
        rnd3 = s2_norm_reg[7] & ((|s2_norm_reg[6:0]) | s2_norm_reg[8]);
        sum3 = {1'b0, s2_norm_reg[31:8]} + {24'd0, rnd3};
        if (sum3[24])
        begin
            s3_mant_next = sum3[24:1];
            s3_exp_next  = {1'b0, s2_pos_reg} + 6'd1;
        end
        else
        begin
            s3_mant_next = sum3[23:0];
            s3_exp_next  = {1'b0, s2_pos_reg};
        end
    end

    // stage 4: quotient estimate by series of 2^-15 shifts; plain result packed
    logic        s4_sign_reg, s4_div_reg, s4_zero_reg;
    logic [5:0]  s4_exp_reg;
    logic [35:0] s4_q0_reg, s4_q0_next;
    logic [31:0] s4_plain_reg, s4_plain_next;
    logic [7:0]  plain_exp;

    always_comb
    begin
        s4_q0_next = {1'b0, s3_mant_reg, 11'd0} + {16'd0, s3_mant_reg[23:4]}
                     + {31'd0, s3_mant_reg[23:19]};
        plain_exp  = {2'b0, s3_exp_reg} + 8'd96;
        s4_plain_next = s3_zero_reg ? 32'd0 : {s3_sign_reg, plain_exp, s3_mant_reg[22:0]};
    end

    // stage 5: remainder, correction and sticky
    logic        s5_sign_reg, s5_div_reg, s5_zero_reg;
    logic [5:0]  s5_exp_reg;
    logic [31:0] s5_plain_reg;
    logic [35:0] s5_q_reg, s5_q_next;
    logic        s5_rnz_reg, s5_rnz_next;
    logic [17:0] rem5;
    logic [2:0]  corr5;

    always_comb
    begin
        rem5  = s4_q0_reg[17:0] - {s4_q0_reg[2:0], 15'd0};
        corr5 = 3'(rem5 >= 18'd32767) + 3'(rem5 >= 18'd65534)
              + 3'(rem5 >= 18'd98301) + 3'(rem5 >= 18'd131068);
        s5_q_next   = s4_q0_reg + {33'd0, corr5};
        s5_rnz_next = (rem5 != 18'd0) && (rem5 != 18'd32767) && (rem5 != 18'd65534)
                   && (rem5 != 18'd98301) && (rem5 != 18'd131068);
    end

    // stage 6: round quotient and pack
    logic [31:0] s6_res_reg, s6_res_next;
    logic [23:0] keep6;
    logic        g6, st6, rnd6;
    logic [24:0] sum6;
    logic [7:0]  exp6;

    always_comb
    begin
        if (s5_q_reg[35])
        begin
            keep6 = s5_q_reg[35:12];
            g6    = s5_q_reg[11];
            st6   = (|s5_q_reg[10:0]) | s5_rnz_reg;
            exp6  = {2'b0, s5_exp_reg} + 8'd113;
        end
        else
        begin
            keep6 = s5_q_reg[34:11];
            g6    = s5_q_reg[10];
            st6   = (|s5_q_reg[9:0]) | s5_rnz_reg;
            exp6  = {2'b0, s5_exp_reg} + 8'd112;
        end
        rnd6 = g6 & (st6 | keep6[0]);
        sum6 = {1'b0, keep6} + {24'd0, rnd6};
        if (sum6[24])
            exp6 = exp6 + 8'd1;
        if (!s5_div_reg)
            s6_res_next = s5_plain_reg;
        else if (s5_zero_reg)
            s6_res_next = 32'd0;
        else
            s6_res_next = {s5_sign_reg, exp6, sum6[24] ? 23'd0 : sum6[22:0]};
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg  <= s1_sign_next;
            s1_mag_reg   <= s1_mag_next;
            s1_div_reg   <= s1_div_next;
            s2_sign_reg  <= s1_sign_reg;
            s2_div_reg   <= s1_div_reg;
            s2_zero_reg  <= s2_zero_next;
            s2_norm_reg  <= s2_norm_next;
            s2_pos_reg   <= s2_pos_next;
            s3_sign_reg  <= s2_sign_reg;
            s3_div_reg   <= s2_div_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_mant_reg  <= s3_mant_next;
            s3_exp_reg   <= s3_exp_next;
            s4_sign_reg  <= s3_sign_reg;
            s4_div_reg   <= s3_div_reg;
            s4_zero_reg  <= s3_zero_reg;
            s4_exp_reg   <= s3_exp_reg;
            s4_q0_reg    <= s4_q0_next;
            s4_plain_reg <= s4_plain_next;
            s5_sign_reg  <= s4_sign_reg;
            s5_div_reg   <= s4_div_reg;
            s5_zero_reg  <= s4_zero_reg;
            s5_exp_reg   <= s4_exp_reg;
            s5_plain_reg <= s4_plain_reg;
            s5_q_reg     <= s5_q_next;
            s5_rnz_reg   <= s5_rnz_next;
            s6_res_reg   <= s6_res_next;
        end
    end

    assign result = s6_res_reg;

endmodule

[sv/sfc_flt2int.sv]
// ----------------------------------------------------------------------------
// sfc_flt2int
// Single float scaled by 32767 or 2^31, truncated and saturated to an
// integer word, four register stages.
// ----------------------------------------------------------------------------
module sfc_flt2int
(
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       sample,
    input  sfc_pkg::fmt_t     out_fmt,
    output logic [31:0]       result
);
    import sfc_pkg::*;

    // stage 1: unpack
    logic        s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_zero_reg;
    logic [7:0]  s1_exp_reg;
    logic [23:0] s1_mant_reg;
    logic        s1_is16_reg, s1_s15_reg;

    // stage 2: scale (with nearest-even rounding for 32767)
    logic        s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_zero_reg, s2_is16_reg;
    logic [24:0] s2_m_reg, s2_m_next;
    logic signed [8:0] s2_t_reg, s2_t_next;
    logic [38:0] prod2;
    logic [23:0] keep2;
    logic        g2, st2;
    logic [3:0]  sh2;

    always_comb
    begin
        prod2 = {s1_mant_reg, 15'd0} - {15'd0, s1_mant_reg};
        if (prod2[38])
        begin
            keep2 = prod2[38:15];
            g2    = prod2[14];
            st2   = |prod2[13:0];
            sh2   = 4'd15;
        end
        else
        begin
            keep2 = prod2[37:14];
            g2    = prod2[13];
            st2   = |prod2[12:0];
            sh2   = 4'd14;
        end
        if (s1_s15_reg)
        begin
            s2_m_next = {1'b0, keep2} + {24'd0, g2 & (st2 | keep2[0])};
            s2_t_next = 9'($signed({2'b00, s1_exp_reg}) - 10'sd150 + $signed({6'd0, sh2}));
        end
        else
        begin
            s2_m_next = {1'b0, s1_mant_reg};
            s2_t_next = 9'($signed({2'b00, s1_exp_reg}) - 10'sd119);
        end
    end

    // stage 3: align to integer
    logic        s3_sign_reg, s3_nan_reg, s3_is16_reg;
    logic        s3_big_reg, s3_big_next;
    logic [32:0] s3_mag_reg, s3_mag_next;
    logic [8:0]  nt3;

    always_comb
    begin
        nt3 = 9'(-s2_t_reg);
        s3_big_next = 1'b0;
        s3_mag_next = 33'd0;
        if (s2_inf_reg)
            s3_big_next = 1'b1;
        else if (s2_zero_reg)
            s3_mag_next = 33'd0;
        else if (s2_t_reg >= 9'sd9)
            s3_big_next = 1'b1;
        else if (s2_t_reg >= 9'sd0)
            s3_mag_next = {8'd0, s2_m_reg} << s2_t_reg[3:0];
        else if (nt3 >= 9'd25)
            s3_mag_next = 33'd0;
        else
            s3_mag_next = {8'd0, s2_m_reg >> nt3[4:0]};
    end

    // stage 4: saturate, apply sign
    logic [31:0] s4_res_reg, s4_res_next;
    logic [32:0] neg4;

    always_comb
    begin
        neg4 = ~s3_mag_reg + 33'd1;
        if (s3_is16_reg)
        begin
            if (s3_nan_reg)
                s4_res_next = 32'h0000_8000;
            else if (!s3_sign_reg)
                s4_res_next = (s3_big_reg || s3_mag_reg > 33'd32767) ? 32'h0000_7fff
                            : {16'd0, s3_mag_reg[15:0]};
            else
                s4_res_next = (s3_big_reg || s3_mag_reg > 33'd32768) ? 32'h0000_8000
                            : {16'd0, neg4[15:0]};
        end
        else
        begin
            if (s3_nan_reg)
                s4_res_next = 32'h8000_0000;
            else if (!s3_sign_reg)
                s4_res_next = (s3_big_reg || s3_mag_reg[32:31] != 2'b00) ? 32'h7fff_ffff
                            : s3_mag_reg[31:0];
            else
                s4_res_next = (s3_big_reg || s3_mag_reg[32:31] != 2'b00) ? 32'h8000_0000
                            : neg4[31:0];
        end
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg <= sample[31];
            s1_exp_reg  <= sample[30:23];
            s1_mant_reg <= {1'b1, sample[22:0]};
            s1_nan_reg  <= (sample[30:23] == 8'hff) && (sample[22:0] != 23'd0);
            s1_inf_reg  <= (sample[30:23] == 8'hff) && (sample[22:0] == 23'd0);
            s1_zero_reg <= (sample[30:23] == 8'h00);
            s1_is16_reg <= (out_fmt == FMT_I16);
            s1_s15_reg  <= (out_fmt != FMT_I32);
            s2_sign_reg <= s1_sign_reg;
            s2_nan_reg  <= s1_nan_reg;
            s2_inf_reg  <= s1_inf_reg;
            s2_zero_reg <= s1_zero_reg;
            s2_is16_reg <= s1_is16_reg;
            s2_m_reg    <= s2_m_next;
            s2_t_reg    <= s2_t_next;
            s3_sign_reg <= s2_sign_reg;
            s3_nan_reg  <= s2_nan_reg;
            s3_is16_reg <= s2_is16_reg;
            s3_big_reg  <= s3_big_next;
            s3_mag_reg  <= s3_mag_next;
            s4_res_reg  <= s4_res_next;
        end
    end

    assign result = s4_res_reg;

endmodule

[sv/sample_format_converter_core.sv]
// ----------------------------------------------------------------------------
// sample_format_converter_core
// Audio sample word conversion among int16, int16 in int32, int32 and float.
// ----------------------------------------------------------------------------
// Takes one sample item per clock while not stalled and returns each result
// in order. The depth is set by the integer-to-float unit
// (normalise, round, divide by 32767 through shift series and correction,
// round again); the float-to-integer unit and the plain integer paths are
// padded to the same depth. A stall on the output halts the whole pipeline,
// so in_stall follows out_stall while a result is waiting. The user must
// change formats only while no items are in flight; this is not enforced.
// ----------------------------------------------------------------------------
`include "sample_format_converter_core_assert.svh"

module sample_format_converter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_in,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] sample_out,
    output logic        last_out
);
    import sfc_pkg::*;

    fmt_t        input_format_reg, output_format_reg;
    logic        en;
    logic [31:0] i2f_res, f2i_res;

    logic        valid_reg [STAGES];
    logic        last_reg  [STAGES];
    path_t       path_reg  [STAGES];
    logic [31:0] simp_reg  [STAGES];

    path_t       path_next;
    logic [31:0] simp_next;
    logic [31:0] sx32;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_format_reg  <= FMT_I16;
            output_format_reg <= FMT_I16;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INPUT_FORMAT:  input_format_reg  <= cfg_data;
                CFG_OUTPUT_FORMAT: output_format_reg <= cfg_data;
                default:           input_format_reg  <= input_format_reg;
            endcase
        end
    end

    // whole pipeline advances unless a result is held at the output
    assign en       = !(valid_reg[STAGES-1] && out_stall);
    assign in_stall = valid_reg[STAGES-1] && out_stall;

    // path choice and the integer-to-integer conversions
    always_comb
    begin
        sx32 = sample_in;
        if (input_format_reg == output_format_reg)
        begin
            path_next = PATH_SIMPLE;
            simp_next = (input_format_reg == FMT_I16) ? {16'd0, sample_in[15:0]} : sample_in;
        end
        else if (output_format_reg == FMT_F32)
        begin
            path_next = PATH_I2F;
            simp_next = 32'd0;
        end
        else if (input_format_reg == FMT_F32)
        begin
            path_next = PATH_F2I;
            simp_next = 32'd0;
        end
        else
        begin
            path_next = PATH_SIMPLE;
            // clamp int16-in-int32 to int16 range
            if (sx32[31] && sx32[31:15] != 17'h1ffff)
                sx32 = 32'h0000_8000;
            else if (!sx32[31] && sx32[31:15] != 17'h0)
                sx32 = 32'h0000_7fff;
            unique case (input_format_reg)
                FMT_I16:
                    simp_next = (output_format_reg == FMT_I16_ON_I32)
                              ? {{16{sample_in[15]}}, sample_in[15:0]}
                              : {sample_in[15:0], 16'd0};
                FMT_I16_ON_I32:
                    simp_next = (output_format_reg == FMT_I16)
                              ? {16'd0, sx32[15:0]} : {sx32[15:0], 16'd0};
                default:
                    simp_next = (output_format_reg == FMT_I16)
                              ? {16'd0, sample_in[31:16]}
                              : {{16{sample_in[31]}}, sample_in[31:16]};
            endcase
        end
    end

    sfc_int2flt u_int2flt
    (
        .clk    (clk),
        .en     (en),
        .sample (sample_in),
        .in_fmt (input_format_reg),
        .result (i2f_res)
    );

    sfc_flt2int u_flt2int
    (
        .clk     (clk),
        .en      (en),
        .sample  (sample_in),
        .out_fmt (output_format_reg),
        .result  (f2i_res)
    );

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < STAGES; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // item payload line; float-to-int result joins at its own depth
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[0] <= last_in;
            path_reg[0] <= path_next;
            simp_reg[0] <= simp_next;
            for (int i = 1; i < STAGES; i++)
            begin
                last_reg[i] <= last_reg[i-1];
                path_reg[i] <= path_reg[i-1];
                if (i == F2I_STAGES && path_reg[i-1] == PATH_F2I)
                    simp_reg[i] <= f2i_res;
                else
                    simp_reg[i] <= simp_reg[i-1];
            end
        end
    end

    assign out_valid  = valid_reg[STAGES-1];
    assign last_out   = last_reg[STAGES-1];
    assign sample_out = (path_reg[STAGES-1] == PATH_I2F) ? i2f_res : simp_reg[STAGES-1];

    // checks
    `SFC_ASSERT_IMPLY(a_i16_upper_zero, out_valid && (output_format_reg == FMT_I16), sample_out[31:16] == 16'h0, "int16 result has upper bits set")
    `SFC_ASSERT_IMPLY(a_i2f_finite, out_valid && (path_reg[STAGES-1] == PATH_I2F), sample_out[30:23] != 8'hff, "integer to float gave inf or NaN")
    `SFC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_reg[0], "accepted item missing from first stage")

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: sample format converter testbench
// Drives sample items through every pair of input and output formats, a
// directed table, then random items, and checks each result word and its last
// flag against a tabled result or a predictor that rounds floats bit-exactly.
// ----------------------------------------------------------------------------
module tb;
    import sfc_pkg::*;

    typedef struct {
        logic [31:0] sample;
        logic        last;
    } sample_item_t;

    typedef struct {
        fmt_t        fi;
        fmt_t        fo;
        logic [31:0] sample;
        logic        last;
        bit          typed;
        logic [31:0] result;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] sample_in;
    logic        last_in;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] sample_out;
    logic        last_out;

    sample_item_t pending_samples[$];
    fmt_t         cur_in_fmt;
    fmt_t         cur_out_fmt;
    int           idle_pct;
    int           stall_pct;
    int           errors;
    int           items_sent;
    int           results_seen;
    table_row_t   directed[$];

    sample_format_converter_core DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last_out   (last_out)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Single float bits to double, subnormals included
    function automatic real f32_to_real(logic [31:0] x);
        logic [10:0] ed;
        real         r;
        if (x[30:23] == 8'd0)
        begin
            r = real'(x[22:0]) * (2.0 ** (-149));
            return x[31] ? -r : r;
        end
        ed = {3'b000, x[30:23]} + 11'd896;
        return $bitstoreal({x[31], ed, x[22:0], 29'b0});
    endfunction

    // Double to single float bits, round to nearest even; normal range only
    function automatic logic [31:0] real_to_f32(real r);
        logic [63:0] b;
        logic [10:0] ed;
        logic [30:0] body;
        logic [28:0] rem;
        b = $realtobits(r);
        if (b[62:0] == 63'd0)
            return {b[63], 31'd0};
        ed   = b[62:52] - 11'd896;
        body = {ed[7:0], b[51:29]};
        rem  = b[28:0];
        if (rem > 29'h1000_0000 || (rem == 29'h1000_0000 && body[0]))
            body = body + 31'd1;
        return {b[63], body};
    endfunction

    // Float to integer: scale, round to float, clamp, truncate toward zero
    function automatic logic [31:0] float_to_int(logic [31:0] x, bit narrow, real scale);
        real p;
        real v;
        int  r;
        if (x[30:23] == 8'hff)
        begin
            if (x[22:0] != 0 || x[31])
                return narrow ? 32'h0000_8000 : 32'h8000_0000;
            return narrow ? 32'h0000_7fff : 32'h7fff_ffff;
        end
        p = f32_to_real(x) * scale;
        if (narrow)
        begin
            if (p >= 32767.0)
                return 32'h0000_7fff;
            if (p <= -32768.0)
                return 32'h0000_8000;
        end
        else
        begin
            if (p >= 2147483648.0)
                return 32'h7fff_ffff;
            if (p <= -2147483648.0)
                return 32'h8000_0000;
        end
        if (p < 1.0 && p > -1.0)
            return 32'd0;
        v = f32_to_real(real_to_f32(p));
        if (!narrow && v >= 2147483648.0)
            return 32'h7fff_ffff;
        r = $rtoi(v);
        if (narrow)
        begin
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return {16'd0, r[15:0]};
        end
        return r;
    endfunction

    function automatic int clamp_i16(int v);
        if (v < -32768)
            return -32768;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    // Expected output word for one sample under the given formats
    function automatic logic [31:0] predict_sample(logic [31:0] w, fmt_t fi, fmt_t fo);
        int s;
        int c;
        if (fi == fo)
            return (fi == FMT_I16) ? {16'd0, w[15:0]} : w;
        case (fi)
            FMT_I16:
            begin
                s = $signed(w[15:0]);
                if (fo == FMT_I16_ON_I32)
                    return s;
                if (fo == FMT_I32)
                    return {w[15:0], 16'd0};
                return real_to_f32(real'(s) / 32767.0);
            end
            FMT_I16_ON_I32:
            begin
                s = $signed(w);
                c = clamp_i16(s);
                if (fo == FMT_I16)
                    return {16'd0, c[15:0]};
                if (fo == FMT_I32)
                    return {c[15:0], 16'd0};
                // round to float first, then divide
                return real_to_f32(f32_to_real(real_to_f32(real'(s))) / 32767.0);
            end
            FMT_I32:
            begin
                if (fo == FMT_I16)
                    return {16'd0, w[31:16]};
                if (fo == FMT_I16_ON_I32)
                    return {{16{w[31]}}, w[31:16]};
                s = $signed(w);
                return real_to_f32(real'(s) / 2147483648.0);
            end
            default:
            begin
                if (fo == FMT_I16)
                    return float_to_int(w, 1'b1, 32767.0);
                if (fo == FMT_I16_ON_I32)
                    return float_to_int(w, 1'b0, 32767.0);
                return float_to_int(w, 1'b0, 2147483648.0);
            end
        endcase
    endfunction

    // Wait until every result has come, then let the pipe empty
    task automatic drain();
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (STAGES + 2) @(posedge clk);
    endtask

    task automatic set_formats(fmt_t fi, fmt_t fo);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_INPUT_FORMAT;
        cfg_data  <= fi;
        @(posedge clk);
        cfg_index <= CFG_OUTPUT_FORMAT;
        cfg_data  <= fo;
        @(posedge clk);
        cfg_write   <= 1'b0;
        cur_in_fmt  = fi;
        cur_out_fmt = fo;
    endtask

    // Offer one item and record its expectation once accepted
    task automatic send_sample(logic [31:0] w, logic l, bit typed, logic [31:0] result);
        sample_item_t e;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= w;
        last_in   <= l;
        do
            @(posedge clk);
        while (in_stall);
        e.sample = typed ? result : predict_sample(w, cur_in_fmt, cur_out_fmt);
        e.last   = l;
        pending_samples.push_back(e);
        items_sent++;
    endtask

    // Random sample word biased towards the interesting regions of a format
    function automatic logic [31:0] random_sample(fmt_t fi);
        logic [31:0] w;
        int          pick;
        w    = $urandom;
        pick = $urandom_range(9);
        if (fi == FMT_F32)
        begin
            if (pick < 5)
                w[30:23] = 8'($urandom_range(100, 160));
            else if (pick == 5)
                w[30:23] = 8'hff;
            else if (pick == 6)
                w[30:23] = 8'd0;
        end
        else if (fi == FMT_I16_ON_I32 && pick < 6)
            w = 32'($signed(w[16:0]));
        else if (pick == 0)
            w = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        return w;
    endfunction

    // Receiver stalls
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Result checker
    always @(posedge clk)
    begin
        sample_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected result sample %h last %b",
                         $realtime, sample_out, last_out);
                errors++;
            end
            else
            begin
                e = pending_samples.pop_front();
                if (sample_out !== e.sample)
                begin
                    $display("%0t: sample_out expected %h actual %h",
                             $realtime, e.sample, sample_out);
                    errors++;
                end
                if (last_out !== e.last)
                begin
                    $display("%0t: last_out expected %b actual %b",
                             $realtime, e.last, last_out);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int        p;
        int        k;
        fmt_t      fi;
        fmt_t      fo;
        table_row_t r;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_INPUT_FORMAT;
        cfg_data  = 2'd0;
        in_valid  = 1'b0;
        sample_in = 32'd0;
        last_in   = 1'b0;
        out_stall = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        errors    = 0;
        items_sent   = 0;
        results_seen = 0;
        cur_in_fmt   = FMT_I16;
        cur_out_fmt  = FMT_I16;

        // input and output format, sample, last, typed result flag, result
        directed = '{
            '{FMT_I16, FMT_I16, 32'h1234_5678, 1'b0, 1'b1, 32'h0000_5678},
            '{FMT_I16, FMT_I32, 32'h0000_8000, 1'b1, 1'b1, 32'h8000_0000},
            '{FMT_I16, FMT_I16_ON_I32, 32'hffff_8000, 1'b0, 1'b1, 32'hffff_8000},
            '{FMT_I16, FMT_F32, 32'h0000_7fff, 1'b0, 1'b1, 32'h3f80_0000},
            '{FMT_I16, FMT_F32, 32'h0000_8000, 1'b1, 1'b0, 32'd0},
            '{FMT_I16_ON_I32, FMT_I16, 32'h0001_2345, 1'b0, 1'b1, 32'h0000_7fff},
            '{FMT_I16_ON_I32, FMT_I32, 32'hfffe_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{FMT_I16_ON_I32, FMT_F32, 32'h8000_0000, 1'b1, 1'b0, 32'd0},
            '{FMT_I32, FMT_I16, 32'h8000_0000, 1'b0, 1'b1, 32'h0000_8000},
            '{FMT_I32, FMT_I16_ON_I32, 32'h8000_0000, 1'b0, 1'b1, 32'hffff_8000},
            '{FMT_I32, FMT_F32, 32'h8000_0000, 1'b0, 1'b1, 32'hbf80_0000},
            '{FMT_I32, FMT_F32, 32'h7fff_ffff, 1'b1, 1'b0, 32'd0},
            '{FMT_F32, FMT_I16, 32'h7fc0_0000, 1'b0, 1'b1, 32'h0000_8000},
            '{FMT_F32, FMT_I16, 32'hbf80_0000, 1'b0, 1'b1, 32'h0000_8001},
            '{FMT_F32, FMT_I16, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000},
            '{FMT_F32, FMT_I16_ON_I32, 32'h7fc0_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{FMT_F32, FMT_I16_ON_I32, 32'h3f80_0000, 1'b1, 1'b1, 32'h0000_7fff},
            '{FMT_F32, FMT_I32, 32'h7f80_0000, 1'b0, 1'b1, 32'h7fff_ffff},
            '{FMT_F32, FMT_I32, 32'h4f00_0000, 1'b0, 1'b1, 32'h7fff_ffff},
            '{FMT_F32, FMT_I32, 32'hcf00_0000, 1'b0, 1'b1, 32'h8000_0000},
            '{FMT_F32, FMT_I32, 32'h3f7f_ffff, 1'b0, 1'b0, 32'd0},
            '{FMT_F32, FMT_F32, 32'hdead_beef, 1'b1, 1'b1, 32'hdead_beef}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, first rows run on reset formats
        foreach (directed[i])
        begin
            r = directed[i];
            if (r.fi != cur_in_fmt || r.fo != cur_out_fmt)
            begin
                // stop offering the last item before the formats change
                in_valid <= 1'b0;
                set_formats(r.fi, r.fo);
            end
            send_sample(r.sample, r.last, r.typed, r.result);
        end

        // Random items over every format pair, idling mode rotating
        for (p = 0; p < 16; p++)
        begin
            in_valid <= 1'b0;
            fi = fmt_t'(p / 4);
            fo = fmt_t'(p % 4);
            set_formats(fi, fo);
            idle_pct  = (p % 4 == 1) ? 49 : (p % 4 == 3) ? 16 : 0;
            stall_pct = (p % 4 == 2) ? 49 : (p % 4 == 3) ? 16 : 0;
            for (k = 0; k < 100; k++)
            begin
                if (p == 9 && k == 50)
                begin
                    // hold off until the pipe is empty
                    in_valid <= 1'b0;
                    while (pending_samples.size() != 0)
                        @(posedge clk);
                end
                send_sample(random_sample(fi), 1'($urandom_range(1)), 1'b0, 32'd0);
            end
        end
        in_valid <= 1'b0;
        drain();

        $display("tb: %0d items sent, %0d results checked, all 16 format pairs",
                 items_sent, results_seen);
        $display("tb: idle and stall mixes on both channels, float specials included");
        if (errors == 0 && pending_samples.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // Timeout
    initial
    begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/sfc_pkg.sv
sv/sfc_int2flt.sv
sv/sfc_flt2int.sv
sv/sample_format_converter_core.sv
verif/tb.sv
